[sv/base64_stream_decoder_unit_defines.svh]
// Assertion macros for the base64 stream decoder.
// Compile with ASSERT_OFF defined to strip every check.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define B64SD_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("b64sd: assertion failed");
// Checked at every edge, reset included.
`define B64SD_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("b64sd: assertion failed");
`else
`define B64SD_ASSERT_RST(lbl, clk, rstn, prop)
`define B64SD_ASSERT(lbl, clk, prop)
`endif

`endif

[sv/b64sd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package b64sd_pkg;

    // Width of the internal saturating byte counter.
    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH = 16;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH  = 2;
    localparam int Q_IDX_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [5:0] SEXTET_PLUS  = 6'h3E;
    localparam logic [5:0] SEXTET_SLASH = 6'h3F;

    // Status codes on the result.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    // A character after classification.
    typedef struct packed {
        logic [5:0] sextet;
        logic       in_alpha;  // character is in the alphabet
        logic       is_pad;    // character is '='
        logic       last;
    } t_cls;

    function automatic t_cls classify(input logic [7:0] c, input logic last);
        t_cls r;
        r          = '0;
        r.last     = last;
        r.is_pad   = (c == PAD_CHAR);
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.sextet   = 6'(c - 8'h41);
            r.in_alpha = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.sextet   = 6'(c - 8'h61 + 8'd26);
            r.in_alpha = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.sextet   = 6'(c - 8'h30 + 8'd52);
            r.in_alpha = 1'b1;
        end else if (c == CHAR_PLUS) begin
            r.sextet   = SEXTET_PLUS;
            r.in_alpha = 1'b1;
        end else if (c == CHAR_SLASH) begin
            r.sextet   = SEXTET_SLASH;
            r.in_alpha = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/b64sd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64sd_front import b64sd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_last_of_message,
    output logic            o_push,
    output t_cls            o_item,
    input  wire logic       i_q_full
);

    logic r_vld;
    logic n_vld;
    t_cls r_item;
    logic accept;

    assign o_push     = r_vld && !i_q_full;
    assign o_in_ready = !r_vld || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_item     = r_item;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= classify(i_char_code, i_last_of_message);
        end
    end

endmodule

`default_nettype wire

[sv/b64sd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64sd_queue import b64sd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cls      i_item,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cls      o_item
);

    t_cls               r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wptr;
    logic [Q_IDX_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rptr];

    function automatic logic [Q_IDX_W-1:0] ptr_inc(input logic [Q_IDX_W-1:0] p);
        return (p == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[sv/b64sd_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module b64sd_back import b64sd_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_empty,
    input  t_cls              i_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [7:0]        o_data_byte,
    output logic              o_byte_valid,
    output logic [1:0]        o_status,
    output logic              o_message_end,
    output logic [15:0]       o_byte_total
);

    // decoder state
    logic [1:0]             r_pos,  n_pos;
    logic [5:0]             r_held, n_held;
    logic                   r_pad,  n_pad;
    logic [1:0]             r_err,  n_err;
    logic [COUNT_WIDTH-1:0] r_cnt,  n_cnt;

    // result register
    logic                   r_ovld;
    logic [7:0]             r_data,   n_data;
    logic                   r_bvld,   n_bvld;
    logic [1:0]             r_status, n_status;
    logic                   r_end;
    logic [COUNT_WIDTH-1:0] r_total;

    logic [COUNT_WIDTH+TOTAL_WIDTH-1:0] total_ext;

    assign o_pop = !i_q_empty && (!r_ovld || i_out_ready);

    always_comb begin
        n_pos    = r_pos + 2'd1;
        n_held   = r_held;
        n_pad    = r_pad;
        n_err    = r_err;
        n_cnt    = r_cnt;
        n_data   = 8'd0;
        n_bvld   = 1'b0;
        if (!r_pad) begin
            if (i_item.is_pad && r_pos[1]) begin
                n_pad = 1'b1;
            end else if (!i_item.in_alpha) begin
                n_err  = ST_BAD_CHAR;
                n_held = 6'd0;
            end else begin
                case (r_pos)
                    2'd1:    n_data = {r_held, i_item.sextet[5:4]};
                    2'd2:    n_data = {r_held[3:0], i_item.sextet[5:2]};
                    2'd3:    n_data = {r_held[1:0], i_item.sextet};
                    default: n_data = 8'd0;
                endcase
                n_bvld = (r_pos != 2'd0);
                n_held = i_item.sextet;
            end
        end
        if (n_bvld && (r_cnt != '1)) begin
            n_cnt = r_cnt + 1'b1;
        end
        n_status = (i_item.last && (n_pos != 2'd0)) ? ST_BAD_LEN : n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_held <= '0;
            r_pad  <= 1'b0;
            r_err  <= ST_OK;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_ovld <= 1'b1;
                if (i_item.last) begin
                    // end of message: fresh state for the next one
                    r_pos  <= '0;
                    r_held <= '0;
                    r_pad  <= 1'b0;
                    r_err  <= ST_OK;
                    r_cnt  <= '0;
                end else begin
                    r_pos  <= n_pos;
                    r_held <= n_held;
                    r_pad  <= n_pad;
                    r_err  <= n_err;
                    r_cnt  <= n_cnt;
                end
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= n_data;
            r_bvld   <= n_bvld;
            r_status <= n_status;
            r_end    <= i_item.last;
            r_total  <= n_cnt;
        end
    end

    assign total_ext     = {{TOTAL_WIDTH{1'b0}}, r_total};
    assign o_out_valid   = r_ovld;
    assign o_data_byte   = r_data;
    assign o_byte_valid  = r_bvld;
    assign o_status      = r_status;
    assign o_message_end = r_end;
    assign o_byte_total  = total_ext[TOTAL_WIDTH-1:0];

endmodule

`default_nettype wire

[sv/base64_stream_decoder_unit.sv]
// Base64 stream decoder: one character in, one result out.
// Path from input transaction to result valid: front register, then queue
// entry popped into the result register. Throughput: one transaction per
// cycle while the result channel keeps i_out_ready high.
// Reset: synchronous, active low; clears group position, held bits, padding
// flag, error code, byte count, queue pointers and count, and the front and result valid flags.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_unit_defines.svh"

module base64_stream_decoder_unit import b64sd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // character channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_last_of_message,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_byte_valid,
    output logic [1:0]       o_status,
    output logic             o_message_end,
    output logic [15:0]      o_byte_total
);

    // Front to queue
    logic q_push;
    t_cls front_item;
    logic q_full;

    // Queue to back
    logic q_pop;
    logic q_empty;
    t_cls back_item;

    // Front: takes the transaction and classifies the character
    // (alphabet lookup, pad detect) into a register stage.
    b64sd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_char_code       (i_char_code),
        .i_last_of_message (i_last_of_message),
        .o_push            (q_push),
        .o_item            (front_item),
        .i_q_full          (q_full)
    );

    // Short queue so that a stalled result does not stop the front until the queue fills.
    b64sd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (back_item)
    );

    // Back: group position, held sextet, padding and error tracking,
    // byte assembly, saturating count, result register.
    b64sd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_item        (back_item),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_byte   (o_data_byte),
        .o_byte_valid  (o_byte_valid),
        .o_status      (o_status),
        .o_message_end (o_message_end),
        .o_byte_total  (o_byte_total)
    );

    // Length error is only ever reported on the closing character.
    `B64SD_ASSERT_RST(a_len_err_at_end, i_clk, i_rst_n, o_out_valid && (o_status == ST_BAD_LEN) |-> o_message_end)
    // A decoded byte always counts, so the total cannot read zero.
    `B64SD_ASSERT_RST(a_total_counts, i_clk, i_rst_n, o_out_valid && o_byte_valid |-> (o_byte_total != 16'd0))
    // No byte, no data.
    `B64SD_ASSERT_RST(a_data_zero, i_clk, i_rst_n, o_out_valid && !o_byte_valid |-> (o_data_byte == 8'd0))
    // Reset drops any pending result.
    `B64SD_ASSERT(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the base64 stream decoder.
// Driver and monitor are clocked always blocks; the initial block only
// fills the queue of pending characters phase by phase and waits for
// the decoder to drain in between.
module tb;
    import b64sd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;       // well past the decoder latency
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASE_CHARS   = 450;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   byte_valid;
        logic [1:0]             status;
        logic                   message_end;
        logic [TOTAL_WIDTH-1:0] byte_total;
    } decode_result_t;

    // ---- DUT connections, all inputs known from time zero ----
    logic                   i_clk             = 1'b0;
    logic                   i_rst_n           = 1'b0;
    logic                   i_in_valid        = 1'b0;
    logic [7:0]             i_char_code       = 8'h00;
    logic                   i_last_of_message = 1'b0;
    logic                   i_out_ready       = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [7:0]             o_data_byte;
    logic                   o_byte_valid;
    logic [1:0]             o_status;
    logic                   o_message_end;
    logic [TOTAL_WIDTH-1:0] o_byte_total;

    base64_stream_decoder_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_char_code       (i_char_code),
        .i_last_of_message (i_last_of_message),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_data_byte       (o_data_byte),
        .o_byte_valid      (o_byte_valid),
        .o_status          (o_status),
        .o_message_end     (o_message_end),
        .o_byte_total      (o_byte_total)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ---- bench state ----
    char_item_t     pending_chars[$];     // characters waiting to be offered
    decode_result_t expected_results[$];  // predicted results, oldest first
    int             chars_queued = 0;
    int             mismatches   = 0;
    int             cycle_count  = 0;
    bit             idle_on      = 1'b1;  // random gaps on both sides
    bit             hold_req     = 1'b0;  // ask the receiver for one long hold-off
    bit             hold_done    = 1'b0;
    int             hold_left    = 0;
    char_item_t     drive_item;
    decode_result_t seen_expect;

    // ---- predictor state, mirrors the decoder after reset ----
    logic [1:0]             grp_pos   = 2'd0;
    logic [5:0]             prev_bits = 6'd0;
    logic                   pad_hit   = 1'b0;
    logic [1:0]             err_code  = ST_OK;
    logic [COUNT_WIDTH-1:0] byte_cnt  = '0;

    // Six-bit value of a character; bit 6 set when it lies in the alphabet.
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
        if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
        if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
        if (c == CHAR_PLUS)       return {1'b1, SEXTET_PLUS};
        if (c == CHAR_SLASH)      return {1'b1, SEXTET_SLASH};
        return 7'd0;
    endfunction

    // Inverse mapping, for building well-formed text.
    function automatic logic [7:0] alpha_char(input int idx);
        if (idx < 26) return 8'("A" + idx);
        if (idx < 52) return 8'("a" + idx - 26);
        if (idx < 62) return 8'("0" + idx - 52);
        return (idx == 62) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    // Advance the predictor by one accepted character and queue its result.
    task automatic decode_char(input char_item_t it);
        logic [6:0]     sx;
        decode_result_t r;
        sx = sextet_lookup(it.code);
        r  = '0;
        if (!pad_hit) begin
            if (it.code == PAD_CHAR && grp_pos >= 2'd2) begin
                pad_hit = 1'b1;
            end else if (!sx[6]) begin
                // outside the alphabet, or '=' too early in the group
                err_code  = ST_BAD_CHAR;
                prev_bits = 6'd0;
            end else begin
                case (grp_pos)
                    2'd1: begin
                        r.data_byte  = {prev_bits, sx[5:4]};
                        r.byte_valid = 1'b1;
                    end
                    2'd2: begin
                        r.data_byte  = {prev_bits[3:0], sx[5:2]};
                        r.byte_valid = 1'b1;
                    end
                    2'd3: begin
                        r.data_byte  = {prev_bits[1:0], sx[5:0]};
                        r.byte_valid = 1'b1;
                    end
                    default: ;
                endcase
                prev_bits = sx[5:0];
            end
        end
        if (r.byte_valid && byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
        grp_pos       = grp_pos + 2'd1;
        // length error wins over a sticky character error
        r.status      = (it.last && grp_pos != 2'd0) ? ST_BAD_LEN : err_code;
        r.message_end = it.last;
        r.byte_total  = TOTAL_WIDTH'(byte_cnt);
        expected_results.push_back(r);
        if (it.last) begin
            grp_pos   = 2'd0;
            prev_bits = 6'd0;
            pad_hit   = 1'b0;
            err_code  = ST_OK;
            byte_cnt  = '0;
        end
    endtask

    // ---- stimulus builders ----
    task automatic queue_char(input logic [7:0] c, input logic last);
        pending_chars.push_back('{code: c, last: last});
        chars_queued++;
    endtask

    task automatic queue_text(input string s, input logic end_msg);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], end_msg && (i == s.len() - 1));
    endtask

    // Mostly well-formed messages with random content; the rest is noise
    // with stray padding, bytes outside the alphabet and odd lengths.
    task automatic queue_random_message();
        int         groups;
        int         pads;
        int         len;
        int         pick;
        logic [7:0] c;
        if ($urandom_range(99) < 75) begin
            groups = $urandom_range(6, 1);
            pads   = $urandom_range(2);
            for (int i = 0; i < groups * 4; i++) begin
                c = alpha_char($urandom_range(63));
                if (i == groups * 4 - 1 && pads >= 1) c = PAD_CHAR;
                if (i == groups * 4 - 2 && pads == 2) c = PAD_CHAR;
                queue_char(c, i == groups * 4 - 1);
            end
        end else begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(99);
                if (pick < 50)      c = alpha_char($urandom_range(63));
                else if (pick < 70) c = PAD_CHAR;
                else                c = 8'($urandom_range(255));
                queue_char(c, i == len - 1);
            end
        end
    endtask

    // Hold the sender back until the decoder has answered everything.
    task automatic wait_drained();
        while (pending_chars.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // ---- driver: offers pending characters, predicts on each transaction ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                decode_char('{code: i_char_code, last: i_last_of_message});
            // payload is only replaced once the current transaction is done
            if (!i_in_valid || o_in_ready) begin
                if (pending_chars.size() != 0 &&
                    !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
                    drive_item = pending_chars.pop_front();
                    i_char_code       <= drive_item.code;
                    i_last_of_message <= drive_item.last;
                    i_in_valid        <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---- monitor: checks each result transaction, throttles ready ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: byte %0h total %0d",
                           o_data_byte, o_byte_total);
                    mismatches++;
                end else begin
                    seen_expect = expected_results.pop_front();
                    if (o_data_byte !== seen_expect.data_byte) begin
                        $error("data_byte: expected %0h, got %0h",
                               seen_expect.data_byte, o_data_byte);
                        mismatches++;
                    end
                    if (o_byte_valid !== seen_expect.byte_valid) begin
                        $error("byte_valid: expected %0d, got %0d",
                               seen_expect.byte_valid, o_byte_valid);
                        mismatches++;
                    end
                    if (o_status !== seen_expect.status) begin
                        $error("status: expected %0d, got %0d",
                               seen_expect.status, o_status);
                        mismatches++;
                    end
                    if (o_message_end !== seen_expect.message_end) begin
                        $error("message_end: expected %0d, got %0d",
                               seen_expect.message_end, o_message_end);
                        mismatches++;
                    end
                    if (o_byte_total !== seen_expect.byte_total) begin
                        $error("byte_total: expected %0d, got %0d",
                               seen_expect.byte_total, o_byte_total);
                        mismatches++;
                    end
                end
            end
            // one long back-pressure spell so the decoder fills and stalls
            if (hold_req && !hold_done) begin
                hold_done   <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
            end
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** base64_stream_decoder_unit: FAILED **");
            $finish;
        end
    end

    // ---- sequencing ----
    initial begin
        int target;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: alphabet extremes, padding at each position, characters
        // after padding, bad bytes, short messages, and the length error
        // taking priority over a character error.
        queue_text("TWFu", 1'b1);
        queue_text("Az09+/==", 1'b1);
        queue_char(PAD_CHAR, 1'b0);     // '=' at position 0 is invalid
        queue_char(8'hFF, 1'b0);
        queue_char("Z", 1'b0);
        queue_char(8'h00, 1'b1);
        queue_text("Q=x", 1'b1);        // '=' at position 1, short length
        queue_text("QU=", 1'b0);
        queue_char(8'h80, 1'b1);        // ignored once padding is seen
        wait_drained();

        // Random with gaps on both sides and one long receiver hold-off.
        target = chars_queued + PHASE_CHARS;
        while (chars_queued < target) queue_random_message();
        hold_req = 1'b1;
        wait_drained();

        // Random, back to back with no gaps at all.
        idle_on = 1'b0;
        target  = chars_queued + PHASE_CHARS;
        while (chars_queued < target) queue_random_message();
        wait_drained();

        // let any stray result transaction surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** base64_stream_decoder_unit: PASSED **");
        end else begin
            $display("** base64_stream_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
